@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the glyph atlas cache rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define GAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// invariant on a plain expression
`define GAC_ASSERT_INV(name, expr, msg) \
  `GAC_ASSERT(name, expr, msg)

`endif

@@ hw/rtl/gac_pkg.sv @@
// types, constants and helper functions of the glyph atlas cache
package gac_pkg;

  localparam int TABLE_SLOTS = 4093;
  localparam int PAD_PIXELS  = 1;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int LOAD_LIMIT  = (TABLE_SLOTS * 3) / 4;
  localparam int CNT_W       = $clog2(LOAD_LIMIT + 2);
  localparam int FOLD        = (1 << SLOT_W) - TABLE_SLOTS;
  localparam int ATLAS_MAX   = 4096;
  localparam int CFG_W       = 13;
  localparam int SUM_W       = CFG_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int HASH_W      = 32;
  localparam int KEY_BYTES   = 10;
  localparam int HASH_STEPS  = KEY_BYTES / 2;
  localparam int STEP_W      = $clog2(HASH_STEPS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_WIDTH  = 2'd0,
    CFG_ATLAS_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_FOLD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_MISS,
    B_WRITE,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [15:0]        font_id;
    logic [31:0]        size_bits;
    logic signed [15:0] glyph_id;
    logic [7:0]         sub_x;
    logic [7:0]         sub_y;
    logic [6:0]         glyph_width;
    logic [6:0]         glyph_height;
    logic signed [7:0]  glyph_left;
    logic signed [7:0]  glyph_top;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic               placed;
    logic [11:0]        atlas_x;
    logic [11:0]        atlas_y;
    logic [6:0]         out_width;
    logic [6:0]         out_height;
    logic signed [7:0]  out_left;
    logic signed [7:0]  out_top;
    logic               cache_cleared;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        key_main;
    logic [15:0]        key_sub;
    logic [6:0]         w;
    logic [6:0]         h;
    logic [7:0]         left;
    logic [7:0]         top;
    logic [SLOT_W-1:0]  start;
  } q_item_t;

  typedef struct packed {
    logic [11:0] y;
    logic [11:0] x;
    logic [7:0]  top;
    logic [7:0]  left;
    logic [6:0]  h;
    logic [6:0]  w;
  } glyph_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key_main;
    logic [15:0] key_sub;
    glyph_t      glyph;
  } slot_t;

  typedef struct packed {
    logic [CFG_W-1:0] aw;
    logic [CFG_W-1:0] ah;
  } cfg_t;

  typedef struct packed {
    logic sweeping;
  } back_status_t;

  // one sdbm byte step: b + h*65599
  function automatic logic [HASH_W-1:0] sdbm_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    sdbm_step = {{(HASH_W-8){1'b0}}, b} + (h << 6) + (h << 16) - h;
  endfunction

endpackage

@@ hw/rtl/gac_in_if.sv @@
// request channel of the glyph atlas cache
interface gac_in_if;
  logic                valid;
  logic                ready;
  gac_pkg::in_item_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/gac_out_if.sv @@
// result channel of the glyph atlas cache
interface gac_out_if;
  logic                valid;
  logic                ready;
  gac_pkg::out_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/gac_front.sv @@
// front end: accepts requests, hashes the key and reduces it to a start slot
module gac_front (
  input  logic                  clk,
  input  logic                  rst_n,
  gac_in_if.sink                in_ch,
  input  gac_pkg::back_status_t back_status,
  output logic                  push_valid,
  input  logic                  push_ready,
  output gac_pkg::q_item_t      push_item
);

  gac_pkg::front_state_t state_r, state_nxt;
  logic [8*gac_pkg::KEY_BYTES-1:0] key_sr_r;
  logic [gac_pkg::HASH_W-1:0]      hash_r;
  logic [gac_pkg::STEP_W-1:0]      step_r;
  gac_pkg::q_item_t                item_r;
  logic                            accept;
  logic                            wide;
  logic [gac_pkg::HASH_W-1:0]      folded;

  assign accept = in_ch.valid && in_ch.ready;
  assign wide   = |hash_r[gac_pkg::HASH_W-1:gac_pkg::SLOT_W];
  // 2^SLOT_W is congruent to FOLD, so hi*FOLD + lo keeps the residue
  assign folded = gac_pkg::HASH_W'(hash_r[gac_pkg::HASH_W-1:gac_pkg::SLOT_W]) *
                  gac_pkg::HASH_W'(gac_pkg::FOLD) +
                  gac_pkg::HASH_W'(hash_r[gac_pkg::SLOT_W-1:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gac_pkg::F_IDLE: if (accept) state_nxt = gac_pkg::F_HASH;
      gac_pkg::F_HASH: begin
        if (step_r == gac_pkg::STEP_W'(gac_pkg::HASH_STEPS - 1)) state_nxt = gac_pkg::F_FOLD;
      end
      gac_pkg::F_FOLD: if (!wide) state_nxt = gac_pkg::F_PUSH;
      gac_pkg::F_PUSH: if (push_ready) state_nxt = gac_pkg::F_IDLE;
      default: state_nxt = gac_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == gac_pkg::F_IDLE) && !back_status.sweeping;
    push_valid  = (state_r == gac_pkg::F_PUSH);
    push_item   = item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gac_pkg::F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) step_r <= '0;
      else if (state_r == gac_pkg::F_HASH) step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gac_pkg::F_IDLE: begin
        if (accept) begin
          key_sr_r         <= {in_ch.data.sub_y, in_ch.data.sub_x, in_ch.data.glyph_id,
                               in_ch.data.size_bits, in_ch.data.font_id};
          hash_r           <= '0;
          item_r.key_main  <= {in_ch.data.glyph_id, in_ch.data.size_bits,
                               in_ch.data.font_id};
          item_r.key_sub   <= {in_ch.data.sub_y, in_ch.data.sub_x};
          item_r.w         <= in_ch.data.glyph_width;
          item_r.h         <= in_ch.data.glyph_height;
          item_r.left      <= in_ch.data.glyph_left;
          item_r.top       <= in_ch.data.glyph_top;
        end
      end
      gac_pkg::F_HASH: begin
        // two key bytes per cycle, lowest byte first
        hash_r   <= gac_pkg::sdbm_step(gac_pkg::sdbm_step(hash_r, key_sr_r[7:0]),
                                       key_sr_r[15:8]);
        key_sr_r <= key_sr_r >> 16;
      end
      gac_pkg::F_FOLD: begin
        if (wide) begin
          hash_r <= folded;
        end else if (hash_r[gac_pkg::SLOT_W-1:0] >=
                     gac_pkg::SLOT_W'(gac_pkg::TABLE_SLOTS)) begin
          item_r.start <= hash_r[gac_pkg::SLOT_W-1:0] -
                          gac_pkg::SLOT_W'(gac_pkg::TABLE_SLOTS);
        end else begin
          item_r.start <= hash_r[gac_pkg::SLOT_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/gac_fifo.sv @@
// short queue between front end and back end
module gac_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  gac_pkg::q_item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output gac_pkg::q_item_t pop_item
);

  gac_pkg::q_item_t              entry_r [gac_pkg::Q_DEPTH];
  logic [gac_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [gac_pkg::Q_CNT_W-1:0]   count_r;
  logic                          do_push, do_pop;

  assign push_ready = count_r != gac_pkg::Q_CNT_W'(gac_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ hw/rtl/gac_back.sv @@
// back end: slot memory, linear probe, shelf packer and result register
`include "assert_macros.svh"

module gac_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gac_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  gac_pkg::q_item_t      q_item,
  output logic                  q_ready,
  output gac_pkg::back_status_t status,
  gac_out_if.source             out_ch
);

  localparam int SW = gac_pkg::SUM_W;
  localparam logic [gac_pkg::SLOT_W-1:0] LAST_SLOT =
    gac_pkg::SLOT_W'(gac_pkg::TABLE_SLOTS - 1);

  gac_pkg::back_state_t  state_r, state_nxt;
  gac_pkg::q_item_t      item_r;
  logic [gac_pkg::SLOT_W-1:0] pos_r, sweep_idx_r, probe_cnt_r;
  logic                  wrapped_r, pend_wr_r, pend_res_r;
  logic [gac_pkg::CNT_W-1:0]  entry_count_r;
  logic [gac_pkg::CFG_W-1:0]  shelf_x_r, shelf_y_r;
  logic [7:0]            shelf_h_r;
  gac_pkg::glyph_t       glyph_r;
  gac_pkg::out_item_t    res_r, out_r;
  logic                  out_valid_r;

  gac_pkg::slot_t        mem [gac_pkg::TABLE_SLOTS];
  gac_pkg::slot_t        rd_r;
  logic                  mem_we;
  logic [gac_pkg::SLOT_W-1:0] wr_addr;
  gac_pkg::slot_t        wr_data;
  logic                  out_load;

  // probe compare
  logic                  key_match;
  assign key_match = (rd_r.key_main == item_r.key_main) && (rd_r.key_sub == item_r.key_sub);

  // miss path
  logic [SW-1:0] pad, w_s, h_s, aw_s, ah_s, sx0, sy0, sx1, sy1, sx2, sy2, x_next;
  logic [7:0]    sh0, sh1, sh2, hp, sh_next;
  logic          clr1, clr2, too_large, new_shelf, clr;

  always_comb begin
    pad       = SW'(gac_pkg::PAD_PIXELS);
    w_s       = SW'(item_r.w);
    h_s       = SW'(item_r.h);
    aw_s      = SW'(cfg.aw);
    ah_s      = SW'(cfg.ah);
    clr1      = entry_count_r == gac_pkg::CNT_W'(gac_pkg::LOAD_LIMIT);
    sx0       = clr1 ? pad : SW'(shelf_x_r);
    sy0       = clr1 ? pad : SW'(shelf_y_r);
    sh0       = clr1 ? 8'd0 : shelf_h_r;
    too_large = (h_s + pad > ah_s) || (w_s + pad > aw_s);
    new_shelf = sx0 + w_s + pad > aw_s;
    sx1       = new_shelf ? pad : sx0;
    sy1       = new_shelf ? sy0 + SW'(sh0) + pad : sy0;
    sh1       = new_shelf ? 8'd0 : sh0;
    // atlas full: start over at the top left corner
    clr2      = sy1 + h_s + pad > ah_s;
    sx2       = clr2 ? pad : sx1;
    sy2       = clr2 ? pad : sy1;
    sh2       = clr2 ? 8'd0 : sh1;
    clr       = clr1 || (!too_large && clr2);
    hp        = 8'(item_r.h) + 8'(gac_pkg::PAD_PIXELS);
    sh_next   = (sh2 < hp) ? hp : sh2;
    x_next    = sx2 + w_s + pad;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gac_pkg::B_SWEEP: begin
        if (sweep_idx_r == LAST_SLOT) begin
          if (pend_wr_r) state_nxt = gac_pkg::B_WRITE;
          else if (pend_res_r) state_nxt = gac_pkg::B_DONE;
          else state_nxt = gac_pkg::B_IDLE;
        end
      end
      gac_pkg::B_IDLE:  if (q_valid) state_nxt = gac_pkg::B_READ;
      gac_pkg::B_READ:  state_nxt = gac_pkg::B_CHECK;
      gac_pkg::B_CHECK: begin
        if (!rd_r.valid) state_nxt = gac_pkg::B_MISS;
        else if (key_match || wrapped_r) state_nxt = gac_pkg::B_DONE;
        else state_nxt = gac_pkg::B_READ;
      end
      gac_pkg::B_MISS: begin
        if (clr) state_nxt = gac_pkg::B_SWEEP;
        else if (too_large) state_nxt = gac_pkg::B_DONE;
        else state_nxt = gac_pkg::B_WRITE;
      end
      gac_pkg::B_WRITE: state_nxt = gac_pkg::B_DONE;
      gac_pkg::B_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = gac_pkg::B_IDLE;
      default: state_nxt = gac_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_ready         = (state_r == gac_pkg::B_IDLE);
    status.sweeping = (state_r == gac_pkg::B_SWEEP);
    mem_we          = (state_r == gac_pkg::B_SWEEP) || (state_r == gac_pkg::B_WRITE);
    wr_addr         = (state_r == gac_pkg::B_SWEEP) ? sweep_idx_r : pos_r;
    wr_data         = '0;
    if (state_r == gac_pkg::B_WRITE) begin
      wr_data.valid    = 1'b1;
      wr_data.key_main = item_r.key_main;
      wr_data.key_sub  = item_r.key_sub;
      wr_data.glyph    = glyph_r;
    end
    out_load        = (state_r == gac_pkg::B_DONE) && (!out_valid_r || out_ch.ready);
    out_ch.valid    = out_valid_r;
    out_ch.data     = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gac_pkg::B_SWEEP;
      sweep_idx_r   <= '0;
      pend_wr_r     <= 1'b0;
      pend_res_r    <= 1'b0;
      entry_count_r <= '0;
      shelf_x_r     <= gac_pkg::CFG_W'(gac_pkg::PAD_PIXELS);
      shelf_y_r     <= gac_pkg::CFG_W'(gac_pkg::PAD_PIXELS);
      shelf_h_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gac_pkg::B_SWEEP) begin
        sweep_idx_r <= (sweep_idx_r == LAST_SLOT) ? '0 : sweep_idx_r + 1'b1;
      end
      if (state_r == gac_pkg::B_MISS) begin
        if (clr) begin
          pend_wr_r  <= !too_large;
          pend_res_r <= 1'b1;
        end
        if (too_large) begin
          if (clr1) begin
            entry_count_r <= '0;
            shelf_x_r     <= gac_pkg::CFG_W'(gac_pkg::PAD_PIXELS);
            shelf_y_r     <= gac_pkg::CFG_W'(gac_pkg::PAD_PIXELS);
            shelf_h_r     <= '0;
          end
        end else begin
          entry_count_r <= (clr ? gac_pkg::CNT_W'(0) : entry_count_r) + 1'b1;
          shelf_x_r     <= x_next[gac_pkg::CFG_W-1:0];
          shelf_y_r     <= sy2[gac_pkg::CFG_W-1:0];
          shelf_h_r     <= sh_next;
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      gac_pkg::B_IDLE: begin
        if (q_valid) begin
          item_r      <= q_item;
          pos_r       <= q_item.start;
          probe_cnt_r <= '0;
          wrapped_r   <= 1'b0;
        end
      end
      gac_pkg::B_CHECK: begin
        if (rd_r.valid && (key_match || wrapped_r)) begin
          res_r.hit           <= 1'b1;
          res_r.placed        <= 1'b1;
          res_r.atlas_x       <= rd_r.glyph.x;
          res_r.atlas_y       <= rd_r.glyph.y;
          res_r.out_width     <= rd_r.glyph.w;
          res_r.out_height    <= rd_r.glyph.h;
          res_r.out_left      <= rd_r.glyph.left;
          res_r.out_top       <= rd_r.glyph.top;
          res_r.cache_cleared <= 1'b0;
        end else if (rd_r.valid) begin
          // walk is bounded: after a full lap fall back to the start slot
          if (probe_cnt_r == LAST_SLOT) begin
            pos_r     <= item_r.start;
            wrapped_r <= 1'b1;
          end else begin
            pos_r <= (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;
          end
          probe_cnt_r <= probe_cnt_r + 1'b1;
        end
      end
      gac_pkg::B_MISS: begin
        // an emptied table places the key at its start slot
        if (clr) pos_r <= item_r.start;
        glyph_r.w    <= item_r.w;
        glyph_r.h    <= item_r.h;
        glyph_r.left <= item_r.left;
        glyph_r.top  <= item_r.top;
        glyph_r.x    <= sx2[11:0];
        glyph_r.y    <= sy2[11:0];
        res_r.hit           <= 1'b0;
        res_r.cache_cleared <= clr;
        if (too_large) begin
          res_r.placed     <= 1'b0;
          res_r.atlas_x    <= '0;
          res_r.atlas_y    <= '0;
          res_r.out_width  <= '0;
          res_r.out_height <= '0;
          res_r.out_left   <= '0;
          res_r.out_top    <= '0;
        end else begin
          res_r.placed     <= 1'b1;
          res_r.atlas_x    <= sx2[11:0];
          res_r.atlas_y    <= sy2[11:0];
          res_r.out_width  <= item_r.w;
          res_r.out_height <= item_r.h;
          res_r.out_left   <= item_r.left;
          res_r.out_top    <= item_r.top;
        end
      end
      default: ;
    endcase
    if (out_load) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[pos_r];
    if (mem_we) mem[wr_addr] <= wr_data;
  end

  `GAC_ASSERT(a_check_follows_read, (state_r == gac_pkg::B_CHECK) |-> ($past(state_r) == gac_pkg::B_READ), "slot compared without a read")
  `GAC_ASSERT(a_sweep_ends, (state_r == gac_pkg::B_SWEEP && sweep_idx_r == LAST_SLOT) |=> (state_r != gac_pkg::B_SWEEP), "clear pass overran the table")
  `GAC_ASSERT_INV(a_load_bound, entry_count_r <= gac_pkg::CNT_W'(gac_pkg::LOAD_LIMIT), "entry count above load limit")
  `GAC_ASSERT_INV(a_shelf_y_bound, shelf_y_r <= gac_pkg::CFG_W'(gac_pkg::ATLAS_MAX), "shelf row beyond atlas")

endmodule

@@ hw/rtl/glyph_atlas_cache.sv @@
// glyph atlas cache top level: config registers, front end, queue and back end
// path: hash, fold, push into the queue, pop, a read and a check per probed slot, then the
// output register; a miss adds the miss and write states, a glyph too large the miss state
// a new request is taken once the last is pushed, so hashing overlaps the back end probe
// reset: a clear pass zeroes the slot memory; no request is taken meanwhile
// a miss that empties the cache runs the same clear pass before its result
module glyph_atlas_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  gac_in_if.sink                          in_ch,
  gac_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [gac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gac_pkg::CFG_W-1:0]       cfg_wdata
);

  logic [gac_pkg::CFG_W-1:0] atlas_w_r, atlas_h_r;
  gac_pkg::cfg_t             cfg;
  gac_pkg::back_status_t     back_status;
  logic                      push_valid, push_ready, pop_valid, pop_ready;
  gac_pkg::q_item_t          push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= gac_pkg::CFG_W'(1024);
      atlas_h_r <= gac_pkg::CFG_W'(1024);
    end else if (cfg_we) begin
      case (gac_pkg::cfg_idx_t'(cfg_index))
        gac_pkg::CFG_ATLAS_WIDTH:  atlas_w_r <= cfg_wdata;
        gac_pkg::CFG_ATLAS_HEIGHT: atlas_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sizes above the atlas limit act as the limit
  always_comb begin
    cfg.aw = (atlas_w_r > gac_pkg::CFG_W'(gac_pkg::ATLAS_MAX)) ?
             gac_pkg::CFG_W'(gac_pkg::ATLAS_MAX) : atlas_w_r;
    cfg.ah = (atlas_h_r > gac_pkg::CFG_W'(gac_pkg::ATLAS_MAX)) ?
             gac_pkg::CFG_W'(gac_pkg::ATLAS_MAX) : atlas_h_r;
  end

  gac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .back_status (back_status),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  gac_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  gac_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_ready (pop_ready),
    .status  (back_status),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the glyph atlas cache: lookup, insert, shelf packing and clears
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 30000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gac_pkg::CFG_IDX_W-1:0] cfg_index = gac_pkg::CFG_ATLAS_WIDTH;
  logic [gac_pkg::CFG_W-1:0] cfg_wdata = '0;

  gac_in_if in_ch();
  gac_out_if out_ch();

  glyph_atlas_cache uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow of the cache contents
  bit                 slot_used [gac_pkg::TABLE_SLOTS];
  logic [63:0]        slot_main [gac_pkg::TABLE_SLOTS];
  logic [15:0]        slot_sub  [gac_pkg::TABLE_SLOTS];
  gac_pkg::out_item_t slot_entry [gac_pkg::TABLE_SLOTS];
  int entry_count, shelf_x, shelf_y, shelf_h;
  int atlas_w_reg = 1024, atlas_h_reg = 1024;

  gac_pkg::in_item_t  pending_reqs [$];
  gac_pkg::out_item_t expected_results [$];
  gac_pkg::in_item_t  key_pool [$];

  int errors = 0, n_results = 0, n_hits = 0, n_clears = 0, n_unplaced = 0;
  int idle_cycles = 0, send_gap = 0, ready_gap = 0;
  bit quiet = 0;

  function automatic void empty_atlas();
    slot_used = '{default: 1'b0};
    entry_count = 0;
    shelf_x = gac_pkg::PAD_PIXELS;
    shelf_y = gac_pkg::PAD_PIXELS;
    shelf_h = 0;
  endfunction

  function automatic int find_slot(logic [63:0] km, logic [15:0] ks, int start);
    int p;
    p = start;
    for (int n = 0; n < gac_pkg::TABLE_SLOTS; n++) begin
      if (!slot_used[p] || (slot_main[p] == km && slot_sub[p] == ks)) return p;
      p = (p + 1) % gac_pkg::TABLE_SLOTS;
    end
    return start;
  endfunction

  function automatic void predict_result(gac_pkg::in_item_t r);
    logic [7:0] kb [10];
    logic [31:0] hv;
    logic [63:0] km;
    logic [15:0] ks;
    int start, pos, aw, ah, w, h;
    gac_pkg::out_item_t res;
    kb = '{r.font_id[7:0], r.font_id[15:8], r.size_bits[7:0], r.size_bits[15:8],
           r.size_bits[23:16], r.size_bits[31:24], r.glyph_id[7:0], r.glyph_id[15:8],
           r.sub_x, r.sub_y};
    hv = '0;
    for (int i = 0; i < 10; i++) hv = {24'd0, kb[i]} + (hv << 6) + (hv << 16) - hv;
    start = int'(hv % 32'(gac_pkg::TABLE_SLOTS));
    km = {r.glyph_id, r.size_bits, r.font_id};
    ks = {r.sub_y, r.sub_x};
    aw = atlas_w_reg > gac_pkg::ATLAS_MAX ? gac_pkg::ATLAS_MAX : atlas_w_reg;
    ah = atlas_h_reg > gac_pkg::ATLAS_MAX ? gac_pkg::ATLAS_MAX : atlas_h_reg;
    res = '0;
    pos = find_slot(km, ks, start);
    if (slot_used[pos]) begin
      res = slot_entry[pos];
      res.hit = 1'b1;
      expected_results.push_back(res);
      return;
    end
    if (entry_count == gac_pkg::LOAD_LIMIT) begin
      empty_atlas();
      res.cache_cleared = 1'b1;
      pos = find_slot(km, ks, start);
    end
    w = r.glyph_width;
    h = r.glyph_height;
    if (h + gac_pkg::PAD_PIXELS > ah || w + gac_pkg::PAD_PIXELS > aw) begin
      expected_results.push_back(res);
      return;
    end
    if (shelf_x + w + gac_pkg::PAD_PIXELS > aw) begin
      shelf_y += shelf_h + gac_pkg::PAD_PIXELS;
      shelf_x = gac_pkg::PAD_PIXELS;
      shelf_h = 0;
    end
    if (shelf_y + h + gac_pkg::PAD_PIXELS > ah) begin
      empty_atlas();
      res.cache_cleared = 1'b1;
      pos = find_slot(km, ks, start);
    end
    res.placed = 1'b1;
    res.atlas_x = 12'(shelf_x);
    res.atlas_y = 12'(shelf_y);
    res.out_width = r.glyph_width;
    res.out_height = r.glyph_height;
    res.out_left = r.glyph_left;
    res.out_top = r.glyph_top;
    expected_results.push_back(res);
    res.cache_cleared = 1'b0;
    slot_used[pos] = 1'b1;
    slot_main[pos] = km;
    slot_sub[pos] = ks;
    slot_entry[pos] = res;
    entry_count++;
    shelf_x += w + gac_pkg::PAD_PIXELS;
    if (shelf_h < h + gac_pkg::PAD_PIXELS) shelf_h = h + gac_pkg::PAD_PIXELS;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_result(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 17);
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pending_reqs.pop_front();
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    gac_pkg::out_item_t e, a;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        n_results++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %p", $time, a);
          errors++;
        end else begin
          e = expected_results.pop_front();
          n_hits += e.hit;
          n_clears += e.cache_cleared;
          n_unplaced += !e.placed;
          check_field("hit", e.hit, a.hit);
          check_field("placed", e.placed, a.placed);
          check_field("atlas_x", e.atlas_x, a.atlas_x);
          check_field("atlas_y", e.atlas_y, a.atlas_y);
          check_field("out_width", e.out_width, a.out_width);
          check_field("out_height", e.out_height, a.out_height);
          check_field("out_left", e.out_left, a.out_left);
          check_field("out_top", e.out_top, a.out_top);
          check_field("cache_cleared", e.cache_cleared, a.cache_cleared);
        end
      end
      if (ready_gap > 0) begin
        ready_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        ready_gap = $urandom_range(0, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a beat", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic gac_pkg::in_item_t make_req(int font, logic [31:0] sz, int gid, int sx,
                                                 int sy, int w, int h, int l, int t);
    gac_pkg::in_item_t r;
    r.font_id = 16'(font);
    r.size_bits = sz;
    r.glyph_id = 16'(gid);
    r.sub_x = 8'(sx);
    r.sub_y = 8'(sy);
    r.glyph_width = 7'(w);
    r.glyph_height = 7'(h);
    r.glyph_left = 8'(l);
    r.glyph_top = 8'(t);
    return r;
  endfunction

  // reuse keys often so hits and evicted keys both show up
  task automatic queue_glyphs(int n, int max_w, int max_h);
    gac_pkg::in_item_t r;
    for (int i = 0; i < n; i++) begin
      if (key_pool.size() > 0 && $urandom_range(0, 9) < 4) begin
        r = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        r = make_req(int'($urandom_range(1, 65535)), $urandom, int'($urandom),
                     int'($urandom), int'($urandom), 0, 0, 0, 0);
        if (key_pool.size() >= 48) key_pool.delete($urandom_range(0, 47));
        key_pool.push_back(r);
      end
      if ($urandom_range(0, 19) == 0) begin
        r.glyph_width = 7'($urandom);
        r.glyph_height = 7'($urandom);
      end else begin
        r.glyph_width = 7'($urandom_range(0, max_w));
        r.glyph_height = 7'($urandom_range(0, max_h));
      end
      r.glyph_left = 8'($urandom);
      r.glyph_top = 8'($urandom);
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_all_done();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [gac_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= gac_pkg::CFG_W'(value);
    if (idx == gac_pkg::CFG_ATLAS_WIDTH) atlas_w_reg = value;
    else if (idx == gac_pkg::CFG_ATLAS_HEIGHT) atlas_h_reg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    empty_atlas();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: key and metric extremes, then repeats that must hit
    pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(65535, 32'hffffffff, -1, 255, 255, 127, 127, -128, 127));
    pending_reqs.push_back(make_req(2, 32'h41800000, -32768, 0, 255, 5, 9, 127, -128));
    pending_reqs.push_back(make_req(3, 32'h3f800000, 32767, 255, 0, 127, 1, -1, 0));
    pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 99, 99, 5, 5));
    pending_reqs.push_back(make_req(65535, 32'hffffffff, -1, 255, 255, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(2, 32'h41800000, -32768, 0, 255, 1, 1, 1, 1));
    wait_all_done();

    // small atlas: exact fit, too large on each axis, shelf overflow, atlas full
    write_reg(gac_pkg::CFG_ATLAS_WIDTH, 16);
    write_reg(gac_pkg::CFG_ATLAS_HEIGHT, 16);
    pending_reqs.push_back(make_req(10, 1, 1, 0, 0, 15, 15, 0, 0));
    pending_reqs.push_back(make_req(10, 1, 2, 0, 0, 16, 3, 0, 0));
    pending_reqs.push_back(make_req(10, 1, 3, 0, 0, 3, 16, 0, 0));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(11, 2, i, 0, 0, 6, 6, i, -i));
    queue_glyphs(20, 15, 15);
    wait_all_done();

    // values above the largest size act as the largest; unused index ignored
    write_reg(gac_pkg::CFG_ATLAS_WIDTH, 8191);
    write_reg(gac_pkg::CFG_ATLAS_HEIGHT, 8191);
    write_reg(gac_pkg::CFG_IDX_W'(2), 100);
    write_reg(gac_pkg::CFG_IDX_W'(3), 100);
    queue_glyphs(350, 127, 127);
    wait_all_done();
    queue_glyphs(250, 127, 127);
    wait_all_done();

    // degenerate sizes: nothing fits
    write_reg(gac_pkg::CFG_ATLAS_WIDTH, 5);
    write_reg(gac_pkg::CFG_ATLAS_HEIGHT, 0);
    queue_glyphs(6, 4, 0);
    wait_all_done();
    write_reg(gac_pkg::CFG_ATLAS_WIDTH, 0);
    wait_all_done();
    write_reg(gac_pkg::CFG_ATLAS_WIDTH, 4096);
    write_reg(gac_pkg::CFG_ATLAS_HEIGHT, 4096);
    wait_all_done();

    // many empty glyphs with fresh keys to grow the table
    for (int i = 0; i < 150; i++)
      pending_reqs.push_back(make_req(i + 1, $urandom, int'($urandom), int'($urandom),
                                      int'($urandom), 0, 0, int'($urandom),
                                      int'($urandom)));
    wait_all_done();

    // medium atlas, no idling
    write_reg(gac_pkg::CFG_ATLAS_WIDTH, 200);
    write_reg(gac_pkg::CFG_ATLAS_HEIGHT, 120);
    quiet = 1;
    queue_glyphs(250, 40, 40);
    wait_all_done();

    $display("%0d results checked: %0d hits, %0d not placed, %0d cache clears",
             n_results, n_hits, n_unplaced, n_clears);
    $display("atlas sizes from 0 to 4096 and beyond, shelf overflow and full-atlas clears");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ glyph_atlas_cache.f @@
+incdir+hw/rtl
hw/rtl/gac_pkg.sv
hw/rtl/gac_in_if.sv
hw/rtl/gac_out_if.sv
hw/rtl/gac_front.sv
hw/rtl/gac_fifo.sv
hw/rtl/gac_back.sv
hw/rtl/glyph_atlas_cache.sv
tb/tb_top.sv
